// ----- hdl/atef_pkg.sv -----
// Shared types, widths and constants of the edge-field stencil update.
package atef_pkg;

	localparam int FRAC_BITS = 14;

	localparam int VAL_W  = 16;
	localparam int DIFF_W = VAL_W + 1;
	localparam int SQ_W   = 32;
	localparam int SSQ_W  = SQ_W + 2;
	localparam int ESUM_W = VAL_W + 2;
	localparam int NB_W   = 35;
	localparam int WT_W   = VAL_W + SQ_W + 1;
	localparam int WSUM_W = WT_W + 2;

	localparam int BETA_W = 12;
	localparam int LAM_W  = 16;
	localparam int EPS_W  = 12;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int RL_W   = LAM_W + EPS_W;
	localparam int L2E_W  = 32;
	localparam int LL_W   = 33;
	localparam int BSQ_W  = BETA_W + SSQ_W;

	localparam logic [IDX_W-1:0] REG_BETA   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LAMBDA = 2'd1;
	localparam logic [IDX_W-1:0] REG_EPS    = 2'd2;

	localparam logic [BETA_W-1:0] BETA_RESET   = 12'd1024;
	localparam logic [LAM_W-1:0]  LAMBDA_RESET = 16'd41;
	localparam logic [EPS_W-1:0]  EPS_RESET    = 12'd2048;

	localparam logic [18:0] FOUR_ONE_DIAG_Q16 = 19'd447508;
	localparam logic signed [17:0] DIAG_Q16 = 18'sd46341;

	// Shifts that bring the products back to the Q.20 working scale.
	localparam int HT_SHIFT = 3 * FRAC_BITS - 11;
	localparam int RT_SHIFT = FRAC_BITS + 16;
	localparam int LS_SHIFT = 2 * FRAC_BITS - 11;

	localparam int HT_W = (HT_SHIFT >= 63) ? 1 : 64 - HT_SHIFT;
	localparam int RT_W = 64 - RT_SHIFT;
	localparam int RMAX_A = (HT_W > RT_W) ? HT_W : RT_W;
	localparam int RIGHT_W = ((RMAX_A > L2E_W) ? RMAX_A : L2E_W) + 2;
	localparam int LS_W = (LS_SHIFT >= BSQ_W) ? 1 : BSQ_W - LS_SHIFT;
	localparam int LEFT_W = ((LS_W > LL_W) ? LS_W : LL_W) + 1;

	localparam int Q_W = 16;
	localparam int X_W = RIGHT_W + FRAC_BITS;
	localparam int CMP_W = (X_W > LEFT_W + Q_W + 1) ? X_W : LEFT_W + Q_W + 1;

	typedef struct packed {
		logic [BETA_W-1:0] beta;
		logic [RL_W-1:0]   rl;
		logic [L2E_W-1:0]  l2e;
		logic [LL_W-1:0]   ll;
	} coef_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] img_nw;
		logic signed [VAL_W-1:0] img_n;
		logic signed [VAL_W-1:0] img_w;
		logic signed [VAL_W-1:0] img_c;
		logic signed [VAL_W-1:0] edge_e;
		logic signed [VAL_W-1:0] edge_w;
		logic signed [VAL_W-1:0] edge_n;
		logic signed [VAL_W-1:0] edge_s;
		logic signed [VAL_W-1:0] edge_nw;
		logic signed [VAL_W-1:0] edge_ne;
		logic signed [VAL_W-1:0] edge_sw;
		logic signed [VAL_W-1:0] edge_se;
	} vtx_t;

	typedef struct packed {
		logic                      valid;
		logic signed [RIGHT_W-1:0] right;
		logic [LEFT_W-1:0]         left;
	} frac_t;

endpackage

// ----- hdl/atef_coef.sv -----
// Configuration registers and the sequencer that derives the stencil coefficients.
module atef_coef (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [atef_pkg::IDX_W-1:0]    wr_index,
	input  logic [atef_pkg::CFG_W-1:0]    wr_data,
	output atef_pkg::coef_t               coef,
	output logic                          busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;

	logic [2:0]                      state_q;
	logic                            busy_q;
	logic [atef_pkg::BETA_W-1:0]     beta_q;
	logic [atef_pkg::LAM_W-1:0]      lambda_q;
	logic [atef_pkg::EPS_W-1:0]      eps_q;
	logic [atef_pkg::RL_W-1:0]       le_q;
	logic [atef_pkg::RL_W-1:0]       rl_q;
	logic [atef_pkg::L2E_W-1:0]      dvd_q;
	logic [atef_pkg::L2E_W-1:0]      l2e_q;
	logic [atef_pkg::EPS_W-1:0]      div_q;
	logic [atef_pkg::EPS_W-1:0]      rem_q;
	logic [4:0]                      cnt_q;
	logic [46:0]                     prod_q;
	logic [atef_pkg::LL_W-1:0]       ll_q;

	logic [atef_pkg::EPS_W-1:0]      e_c;
	logic [atef_pkg::EPS_W:0]        trial_c;
	logic                            ge_c;
	logic                            wr_hit;

	assign e_c = (eps_q == '0) ? atef_pkg::EPS_W'(1) : eps_q;
	assign trial_c = {rem_q, dvd_q[atef_pkg::L2E_W-1]};
	assign ge_c = (trial_c >= {1'b0, div_q});
	assign wr_hit = wr_en && (wr_index == atef_pkg::REG_BETA ||
		wr_index == atef_pkg::REG_LAMBDA || wr_index == atef_pkg::REG_EPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			busy_q   <= 1'b1;
			beta_q   <= atef_pkg::BETA_RESET;
			lambda_q <= atef_pkg::LAMBDA_RESET;
			eps_q    <= atef_pkg::EPS_RESET;
		end else if (wr_hit) begin
			state_q <= ST_LOAD;
			busy_q  <= 1'b1;
			case (wr_index)
				atef_pkg::REG_BETA:   beta_q   <= wr_data[atef_pkg::BETA_W-1:0];
				atef_pkg::REG_LAMBDA: lambda_q <= wr_data[atef_pkg::LAM_W-1:0];
				atef_pkg::REG_EPS:    eps_q    <= wr_data[atef_pkg::EPS_W-1:0];
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Bit-serial restoring division; the quotient shifts into the dividend register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				le_q  <= atef_pkg::RL_W'(lambda_q) * atef_pkg::RL_W'(e_c);
				dvd_q <= {1'b0, lambda_q, 15'b0} + atef_pkg::L2E_W'(e_c >> 1);
				div_q <= e_c;
				rem_q <= '0;
				cnt_q <= 5'd31;
			end
			ST_DIV: begin
				rem_q <= ge_c ? atef_pkg::EPS_W'(trial_c - {1'b0, div_q})
					: atef_pkg::EPS_W'(trial_c);
				dvd_q <= {dvd_q[atef_pkg::L2E_W-2:0], ge_c};
				cnt_q <= cnt_q - 5'd1;
			end
			ST_MUL: begin
				prod_q <= 47'(le_q) * 47'(atef_pkg::FOUR_ONE_DIAG_Q16);
			end
			ST_SUM: begin
				rl_q  <= le_q;
				l2e_q <= dvd_q;
				ll_q  <= atef_pkg::LL_W'((prod_q + 47'd32768) >> 16)
					+ atef_pkg::LL_W'(dvd_q);
			end
			default: ;
		endcase
	end

	assign coef = '{beta: beta_q, rl: rl_q, l2e: l2e_q, ll: ll_q};
	assign busy = busy_q;

endmodule

// ----- hdl/atef_front.sv -----
// Stencil arithmetic: differences, squares, weighted sums and the numerator and denominator.
module atef_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  atef_pkg::vtx_t       vtx,
	input  atef_pkg::coef_t      coef,
	output atef_pkg::frac_t      frac
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [atef_pkg::DIFF_W-1:0] ue_s1, uw_s1, un_s1, us_s1;
	logic signed [atef_pkg::ESUM_W-1:0] esum_s1, dsum_s1;
	logic signed [atef_pkg::VAL_W-1:0]  ve_s1, vw_s1, vn_s1, vs_s1;

	logic [atef_pkg::SQ_W-1:0]          qe_s2, qw_s2, qn_s2, qs_s2;
	logic signed [atef_pkg::NB_W-1:0]   nb_s2;
	logic signed [atef_pkg::VAL_W-1:0]  ve_s2, vw_s2, vn_s2, vs_s2;

	logic signed [atef_pkg::WT_W-1:0]   we_s3, ww_s3, wn_s3, ws_s3;
	logic [atef_pkg::SSQ_W-1:0]         ssq_s3;
	logic [45:0]                        plo_s3;
	logic signed [45:0]                 phi_s3;

	logic signed [atef_pkg::WSUM_W-1:0] wsum_s4;
	logic signed [63:0]                 rprod_s4;
	logic [atef_pkg::BSQ_W-1:0]         bsq_s4;

	logic [37:0]                        hlo_s5;
	logic signed [37:0]                 hhi_s5;
	logic signed [atef_pkg::RIGHT_W-1:0] rterm_s5;
	logic [atef_pkg::LEFT_W-1:0]        left_s5;

	logic signed [atef_pkg::RIGHT_W-1:0] right_s6;
	logic [atef_pkg::LEFT_W-1:0]        left_s6;

	logic signed [2*atef_pkg::DIFF_W-1:0] sqe_c, sqw_c, sqn_c, sqs_c;
	logic signed [35:0]                 dprod_c;
	logic signed [atef_pkg::WT_W-1:0]   we_c, ww_c, wn_c, ws_c;
	logic signed [45:0]                 phi_c;
	logic signed [37:0]                 hhi_c;
	logic signed [63:0]                 rt_c, hprod_c, ht_c;

	assign sqe_c = ue_s1 * ue_s1;
	assign sqw_c = uw_s1 * uw_s1;
	assign sqn_c = un_s1 * un_s1;
	assign sqs_c = us_s1 * us_s1;
	assign dprod_c = atef_pkg::DIAG_Q16 * dsum_s1;

	assign we_c = ve_s2 * $signed({1'b0, qe_s2});
	assign ww_c = vw_s2 * $signed({1'b0, qw_s2});
	assign wn_c = vn_s2 * $signed({1'b0, qn_s2});
	assign ws_c = vs_s2 * $signed({1'b0, qs_s2});
	assign phi_c = $signed({1'b0, coef.rl}) * $signed(nb_s2[34:18]);

	assign hhi_c = $signed({1'b0, coef.beta}) * $signed(wsum_s4[50:26]);
	assign rt_c = rprod_s4 >>> atef_pkg::RT_SHIFT;

	assign hprod_c = {hhi_s5, 26'b0} + {26'b0, hlo_s5};
	assign ht_c = hprod_c >>> atef_pkg::HT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ue_s1 <= {vtx.img_c[15], vtx.img_c} - {vtx.img_n[15], vtx.img_n};
			uw_s1 <= {vtx.img_w[15], vtx.img_w} - {vtx.img_nw[15], vtx.img_nw};
			un_s1 <= {vtx.img_n[15], vtx.img_n} - {vtx.img_nw[15], vtx.img_nw};
			us_s1 <= {vtx.img_c[15], vtx.img_c} - {vtx.img_w[15], vtx.img_w};
			esum_s1 <= {{2{vtx.edge_e[15]}}, vtx.edge_e} + {{2{vtx.edge_w[15]}}, vtx.edge_w}
				+ {{2{vtx.edge_n[15]}}, vtx.edge_n} + {{2{vtx.edge_s[15]}}, vtx.edge_s};
			dsum_s1 <= {{2{vtx.edge_ne[15]}}, vtx.edge_ne}
				+ {{2{vtx.edge_nw[15]}}, vtx.edge_nw}
				+ {{2{vtx.edge_se[15]}}, vtx.edge_se}
				+ {{2{vtx.edge_sw[15]}}, vtx.edge_sw};
			ve_s1 <= vtx.edge_e;
			vw_s1 <= vtx.edge_w;
			vn_s1 <= vtx.edge_n;
			vs_s1 <= vtx.edge_s;

			qe_s2 <= sqe_c[atef_pkg::SQ_W-1:0];
			qw_s2 <= sqw_c[atef_pkg::SQ_W-1:0];
			qn_s2 <= sqn_c[atef_pkg::SQ_W-1:0];
			qs_s2 <= sqs_c[atef_pkg::SQ_W-1:0];
			nb_s2 <= {esum_s1[17], esum_s1, 16'b0} + dprod_c[atef_pkg::NB_W-1:0];
			ve_s2 <= ve_s1;
			vw_s2 <= vw_s1;
			vn_s2 <= vn_s1;
			vs_s2 <= vs_s1;

			we_s3 <= we_c;
			ww_s3 <= ww_c;
			wn_s3 <= wn_c;
			ws_s3 <= ws_c;
			ssq_s3 <= atef_pkg::SSQ_W'(qe_s2) + atef_pkg::SSQ_W'(qw_s2)
				+ atef_pkg::SSQ_W'(qn_s2) + atef_pkg::SSQ_W'(qs_s2);
			plo_s3 <= 46'(coef.rl) * 46'(nb_s2[17:0]);
			phi_s3 <= phi_c;

			wsum_s4 <= {{2{we_s3[48]}}, we_s3} + {{2{ww_s3[48]}}, ww_s3}
				+ {{2{wn_s3[48]}}, wn_s3} + {{2{ws_s3[48]}}, ws_s3};
			rprod_s4 <= {phi_s3, 18'b0} + {18'b0, plo_s3};
			bsq_s4 <= atef_pkg::BSQ_W'(coef.beta) * atef_pkg::BSQ_W'(ssq_s3);

			hlo_s5 <= 38'(coef.beta) * 38'(wsum_s4[25:0]);
			hhi_s5 <= hhi_c;
			rterm_s5 <= rt_c[atef_pkg::RIGHT_W-1:0];
			left_s5 <= atef_pkg::LEFT_W'(bsq_s4 >> atef_pkg::LS_SHIFT)
				+ atef_pkg::LEFT_W'(coef.ll);

			right_s6 <= rterm_s5 - ht_c[atef_pkg::RIGHT_W-1:0]
				+ atef_pkg::RIGHT_W'(coef.l2e);
			left_s6 <= left_s5;
		end
	end

	assign frac = '{valid: v_s6, right: right_s6, left: left_s6};

endmodule

// ----- hdl/atef_div.sv -----
// Pipelined restoring divider with sign handling and saturation of the quotient.
module atef_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  atef_pkg::frac_t                frac,
	output logic                           valid,
	output logic signed [atef_pkg::Q_W-1:0] quot,
	output logic                           clip
);

	localparam int NSTEP = atef_pkg::Q_W;

	logic                          v_s   [0:NSTEP];
	logic [atef_pkg::CMP_W-1:0]    x_s   [0:NSTEP];
	logic [atef_pkg::Q_W-1:0]      q_s   [0:NSTEP];
	logic [atef_pkg::LEFT_W-1:0]   den_s [0:NSTEP];
	logic                          neg_s [0:NSTEP];
	logic                          pos_s [0:NSTEP];
	logic                          zero_s[0:NSTEP];
	logic                          ovf_s [0:NSTEP];

	logic                          v_out_q;
	logic signed [atef_pkg::Q_W-1:0] quot_q;
	logic                          clip_q;

	logic                          neg_c;
	logic [atef_pkg::RIGHT_W-1:0]  num_c;
	logic [atef_pkg::CMP_W-1:0]    x_c;
	logic [atef_pkg::Q_W-1:0]      qf_c;
	logic                          over_c;

	assign neg_c = frac.right[atef_pkg::RIGHT_W-1];
	assign num_c = neg_c ? atef_pkg::RIGHT_W'(-frac.right) : atef_pkg::RIGHT_W'(frac.right);
	assign x_c = atef_pkg::CMP_W'(num_c) << atef_pkg::FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= frac.valid;
		end
	end

	// A quotient of 2^16 or more saturates whatever its sign.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x_c;
			q_s[0]    <= '0;
			den_s[0]  <= frac.left;
			neg_s[0]  <= neg_c;
			pos_s[0]  <= !neg_c && (num_c != '0);
			zero_s[0] <= (frac.left == '0);
			ovf_s[0]  <= (x_c >= (atef_pkg::CMP_W'(frac.left) << atef_pkg::Q_W));
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		localparam int K = NSTEP - 1 - i;
		logic [atef_pkg::CMP_W-1:0] dk;
		logic                       ge;

		assign dk = atef_pkg::CMP_W'(den_s[i]) << K;
		assign ge = (x_s[i] >= dk);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= ge ? x_s[i] - dk : x_s[i];
				q_s[i+1]    <= q_s[i] | (ge ? atef_pkg::Q_W'(1) << K : '0);
				den_s[i+1]  <= den_s[i];
				neg_s[i+1]  <= neg_s[i];
				pos_s[i+1]  <= pos_s[i];
				zero_s[i+1] <= zero_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	assign qf_c = q_s[NSTEP];
	assign over_c = neg_s[NSTEP] ? (qf_c > 16'h8000) : (qf_c > 16'h7FFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_q <= zero_s[NSTEP] || ovf_s[NSTEP] || over_c;
			if (zero_s[NSTEP]) begin
				quot_q <= pos_s[NSTEP] ? 16'sh7FFF : (neg_s[NSTEP] ? 16'sh8000 : 16'sh0000);
			end else if (ovf_s[NSTEP] || over_c) begin
				quot_q <= neg_s[NSTEP] ? 16'sh8000 : 16'sh7FFF;
			end else begin
				quot_q <= neg_s[NSTEP] ? $signed(-qf_c) : $signed(qf_c);
			end
		end
	end

	assign valid = v_out_q;
	assign quot = quot_q;
	assign clip = clip_q;

endmodule

// ----- hdl/at_edge_field_stencil_update.sv -----
// Top level of the edge-field stencil update: coefficient unit, stencil front end, divider.
//
//   channel   direction  handshake              payload
//   vtx       in         vtx_valid / vtx_stall  img_nw .. img_c, edge_e .. edge_se
//   res       out        res_valid / res_stall  edge_new, clipped
//   config    in         wr_en                  wr_index, wr_data
//
// One word per cycle while vtx_stall is low; a word's result passes six stencil
// stages, one divider set-up stage, sixteen divide steps and one output stage.
// After reset and after each write to beta, lambda or eps, the coefficient sequencer
// runs one load, 32 division steps, one multiply and one sum with vtx_stall high.
// A stalled result holds the whole pipeline, so no word is dropped or repeated.
module at_edge_field_stencil_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [atef_pkg::IDX_W-1:0]    wr_index,
	input  logic [atef_pkg::CFG_W-1:0]    wr_data,
	input  logic                          vtx_valid,
	output logic                          vtx_stall,
	input  logic signed [15:0]            img_nw,
	input  logic signed [15:0]            img_n,
	input  logic signed [15:0]            img_w,
	input  logic signed [15:0]            img_c,
	input  logic signed [15:0]            edge_e,
	input  logic signed [15:0]            edge_w,
	input  logic signed [15:0]            edge_n,
	input  logic signed [15:0]            edge_s,
	input  logic signed [15:0]            edge_nw,
	input  logic signed [15:0]            edge_ne,
	input  logic signed [15:0]            edge_sw,
	input  logic signed [15:0]            edge_se,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [15:0]            edge_new,
	output logic                          clipped
);

	atef_pkg::coef_t coef;
	atef_pkg::vtx_t  vtx;
	atef_pkg::frac_t frac;
	logic            busy;
	logic            en;

	assign en = !(res_valid && res_stall);
	assign vtx_stall = busy || !en;

	assign vtx = '{img_nw: img_nw, img_n: img_n, img_w: img_w, img_c: img_c,
		edge_e: edge_e, edge_w: edge_w, edge_n: edge_n, edge_s: edge_s,
		edge_nw: edge_nw, edge_ne: edge_ne, edge_sw: edge_sw, edge_se: edge_se};

	atef_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef),
		.busy     (busy)
	);

	atef_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (vtx_valid && !busy),
		.vtx      (vtx),
		.coef     (coef),
		.frac     (frac)
	);

	atef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.frac   (frac),
		.valid  (res_valid),
		.quot   (edge_new),
		.clip   (clipped)
	);

endmodule

// ----- dv/atef_checker.sv -----
// Checker for the edge-field stencil update: predicts each result and compares it.
module atef_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [atef_pkg::IDX_W-1:0] wr_index,
	input  logic [atef_pkg::CFG_W-1:0] wr_data,
	input  logic                       vtx_valid,
	input  logic                       vtx_stall,
	input  atef_pkg::vtx_t             vtx,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  logic signed [15:0]         edge_new,
	input  logic                       clipped,
	output int                         errors,
	output int                         pending
);
	import atef_pkg::*;

	typedef logic signed [95:0] wide_t;

	typedef struct packed {
		logic signed [15:0] edge_new;
		logic               clipped;
	} edge_res_t;

	edge_res_t expected_edges[$];
	logic [BETA_W-1:0] beta;
	logic [LAM_W-1:0]  lambda;
	logic [EPS_W-1:0]  eps;
	wide_t rl, l2e, ll;

	assign pending = expected_edges.size();

	task automatic derive_coefs();
		wide_t e, le, lam, k;
		begin
			e   = (eps == 0) ? 1 : eps;
			lam = lambda;
			k   = FOUR_ONE_DIAG_Q16;
			le  = lam * e;
			rl  = le;
			l2e = ((lam <<< 15) + (e >>> 1)) / e;
			ll  = ((le * k + 32768) >>> 16) + l2e;
		end
	endtask

	function automatic edge_res_t predict_edge(vtx_t v);
		wide_t nw, n, w, c, ue, uw, un, us, ue2, uw2, un2, us2, sum_sq;
		wide_t weighted, hterm, nb, rterm, right, left, b, d, num, q, lim;
		edge_res_t r;
		logic neg;
		begin
			nw = v.img_nw; n = v.img_n; w = v.img_w; c = v.img_c;
			b  = beta;
			d  = DIAG_Q16;
			ue = c - n; uw = w - nw; un = n - nw; us = c - w;
			ue2 = ue * ue; uw2 = uw * uw; un2 = un * un; us2 = us * us;
			sum_sq = ue2 + uw2 + un2 + us2;
			weighted = wide_t'(v.edge_e) * ue2 + wide_t'(v.edge_w) * uw2
				+ wide_t'(v.edge_n) * un2 + wide_t'(v.edge_s) * us2;
			hterm = (b * weighted) >>> (3 * FRAC_BITS - 11);
			nb = (wide_t'(v.edge_e) + wide_t'(v.edge_w) + wide_t'(v.edge_n)
				+ wide_t'(v.edge_s)) * 65536
				+ d * (wide_t'(v.edge_ne) + wide_t'(v.edge_nw)
				+ wide_t'(v.edge_se) + wide_t'(v.edge_sw));
			rterm = (rl * nb) >>> (FRAC_BITS + 16);
			right = rterm - hterm + l2e;
			left  = ((b * sum_sq) >>> (2 * FRAC_BITS - 11)) + ll;
			neg = right < 0;
			num = neg ? -right : right;
			lim = neg ? 32768 : 32767;
			r.clipped = 1'b0;
			if (left == 0) begin
				r.clipped = 1'b1;
				q = (right == 0) ? 0 : lim;
			end else begin
				q = (num <<< FRAC_BITS) / left;
				if (q > lim) begin
					r.clipped = 1'b1;
					q = lim;
				end
			end
			q = neg ? -q : q;
			r.edge_new = q[15:0];
			return r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edge_res_t exp_r;
		if (!arst_n) begin
			beta   = BETA_RESET;
			lambda = LAMBDA_RESET;
			eps    = EPS_RESET;
			derive_coefs();
			expected_edges.delete();
			errors = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_BETA: begin
						beta = wr_data[BETA_W-1:0];
						derive_coefs();
					end
					REG_LAMBDA: begin
						lambda = wr_data[LAM_W-1:0];
						derive_coefs();
					end
					REG_EPS: begin
						eps = wr_data[EPS_W-1:0];
						derive_coefs();
					end
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (expected_edges.size() == 0) begin
					$error("result word with nothing expected: edge_new %0d", edge_new);
					errors++;
				end else begin
					exp_r = expected_edges.pop_front();
					if (edge_new !== exp_r.edge_new) begin
						$error("edge_new: expected %0d, actual %0d", exp_r.edge_new, edge_new);
						errors++;
					end
					if (clipped !== exp_r.clipped) begin
						$error("clipped: expected %0d, actual %0d", exp_r.clipped, clipped);
						errors++;
					end
				end
			end
			if (vtx_valid && !vtx_stall)
				expected_edges.push_back(predict_edge(vtx));
		end
	end

	final begin
		if (expected_edges.size() != 0)
			$error("%0d expected result words never arrived", expected_edges.size());
	end
endmodule

// ----- dv/tb_at_edge_field_stencil_update.sv -----
// Testbench top of the edge-field stencil update: stimulus, idling and verdict.
module tb_at_edge_field_stencil_update;
	import atef_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic clk, arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;
	logic vtx_valid, vtx_stall, res_valid, res_stall, clipped;
	logic signed [15:0] edge_new;
	vtx_t word;
	int errors, pending;
	int hold_cycles;
	bit no_idle, hold_req;

	at_edge_field_stencil_update DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.img_nw(word.img_nw), .img_n(word.img_n), .img_w(word.img_w), .img_c(word.img_c),
		.edge_e(word.edge_e), .edge_w(word.edge_w), .edge_n(word.edge_n),
		.edge_s(word.edge_s), .edge_nw(word.edge_nw), .edge_ne(word.edge_ne),
		.edge_sw(word.edge_sw), .edge_se(word.edge_se),
		.res_valid(res_valid), .res_stall(res_stall),
		.edge_new(edge_new), .clipped(clipped)
	);

	atef_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(word),
		.res_valid(res_valid), .res_stall(res_stall),
		.edge_new(edge_new), .clipped(clipped),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		int burst;
		burst = 0;
		hold_cycles = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_cycles = 150;
				res_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				res_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 6);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [15:0] pick_value(int mode, logic signed [15:0] base);
		logic signed [15:0] extremes[5];
		begin
			extremes = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh4000};
			case (mode)
				0: return 16'($urandom());
				1: return base + $signed(16'($urandom_range(0, 512))) - 16'sd256;
				2: return extremes[$urandom_range(0, 4)];
				default: return 16'($urandom_range(0, 16384));
			endcase
		end
	endfunction

	function automatic vtx_t random_word();
		vtx_t w;
		int mode;
		logic signed [15:0] base;
		begin
			mode = $urandom_range(0, 3);
			base = 16'($urandom_range(0, 16384));
			w.img_nw = pick_value(mode, base);
			w.img_n  = pick_value(mode, base);
			w.img_w  = pick_value(mode, base);
			w.img_c  = pick_value(mode, base);
			base = 16'($urandom_range(0, 16384));
			w.edge_e  = pick_value(mode, base);
			w.edge_w  = pick_value(mode, base);
			w.edge_n  = pick_value(mode, base);
			w.edge_s  = pick_value(mode, base);
			w.edge_nw = pick_value(mode, base);
			w.edge_ne = pick_value(mode, base);
			w.edge_sw = pick_value(mode, base);
			w.edge_se = pick_value(mode, base);
			return w;
		end
	endfunction

	// Offers one word from a falling edge and returns at the falling edge after it is taken.
	task automatic send_word(vtx_t w);
		begin
			if (!no_idle && $urandom_range(0, 4) == 0) begin
				vtx_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			word <= w;
			vtx_valid <= 1'b1;
			@(posedge clk);
			while (vtx_stall) @(posedge clk);
			@(negedge clk);
		end
	endtask

	task automatic drain();
		begin
			vtx_valid <= 1'b0;
			@(negedge clk);
			while (pending != 0) @(negedge clk);
			repeat (30) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		begin
			wr_en <= 1'b1;
			wr_index <= idx;
			wr_data <= data;
			@(negedge clk);
			wr_en <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic fill_word(output vtx_t w, input logic signed [15:0] img,
		input logic signed [15:0] edge_v);
		begin
			w.img_nw = img; w.img_n = img; w.img_w = img; w.img_c = img;
			w.edge_e = edge_v; w.edge_w = edge_v; w.edge_n = edge_v; w.edge_s = edge_v;
			w.edge_nw = edge_v; w.edge_ne = edge_v; w.edge_sw = edge_v; w.edge_se = edge_v;
		end
	endtask

	initial begin
		vtx_t w;
		logic signed [15:0] vals[4];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		vtx_valid = 1'b0;
		word = '0;
		no_idle = 0;
		hold_req = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words under the reset settings.
		vals = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh4000};
		foreach (vals[i]) begin
			fill_word(w, vals[i], vals[i]);
			send_word(w);
			fill_word(w, vals[i], ~vals[i]);
			send_word(w);
		end
		fill_word(w, 16'sh7fff, 16'sh7fff);
		w.img_nw = 16'sh8000; w.img_w = 16'sh8000;
		send_word(w);
		w.img_n = 16'sh8000; w.img_c = 16'sh7fff;
		w.edge_e = 16'sh8000; w.edge_s = 16'sh8000; w.edge_nw = 16'sh8000;
		send_word(w);
		fill_word(w, 16'sh0000, 16'sh8000);
		w.img_c = 16'sh7fff;
		send_word(w);
		drain();

		// Zero denominator: no lambda term and image differences too small to register.
		write_reg(REG_BETA, 16'd1);
		write_reg(REG_LAMBDA, 16'd0);
		fill_word(w, 16'sh0000, 16'sh7fff);
		w.img_c = 16'sd255;
		send_word(w);
		fill_word(w, 16'sh0000, 16'sh8000);
		w.img_c = 16'sd255;
		send_word(w);
		fill_word(w, 16'sh1234, 16'sh0000);
		send_word(w);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_BETA, 16'd0);
					write_reg(REG_LAMBDA, 16'hffff);
					write_reg(REG_EPS, 16'd1);
				end
				1: begin
					write_reg(REG_BETA, 16'd2560);
					write_reg(REG_LAMBDA, 16'hffff);
					write_reg(REG_EPS, 16'd2560);
				end
				2: begin
					write_reg(REG_BETA, 16'hffff);
					write_reg(REG_LAMBDA, 16'd0);
					write_reg(REG_EPS, 16'd0);
				end
				3: begin
					write_reg(REG_BETA, 16'd1024);
					write_reg(REG_LAMBDA, 16'd41);
					write_reg(REG_EPS, 16'd2048);
					write_reg(REG_UNUSED, 16'($urandom()));
				end
				default: begin
					write_reg(REG_BETA, 16'($urandom_range(0, 2560)));
					write_reg(REG_LAMBDA, 16'($urandom()));
					write_reg(REG_EPS, 16'($urandom_range(1, 2560))
						| (16'($urandom_range(0, 1)) << 12));
				end
			endcase
			if (phase == 8) no_idle = 1;
			for (int k = 0; k < 65; k++) begin
				if (phase == 2 && k == 5) hold_req = 1;
				if (phase == 4 && k == 30) begin
					vtx_valid <= 1'b0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
				send_word(random_word());
			end
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/atef_pkg.sv
hdl/atef_coef.sv
hdl/atef_front.sv
hdl/atef_div.sv
hdl/at_edge_field_stencil_update.sv
dv/atef_checker.sv
dv/tb_at_edge_field_stencil_update.sv
